// ===== rtl/sacts_pkg.sv =====
// sacts_pkg: shared types, constants and helpers of the cache tag store
// depends on nothing; used by sacts_victim, set_assoc_cache_tag_store_top and the bench
`timescale 1ns / 1ps

package sacts_pkg;

   localparam int ADDR_BITS     = 40;
   localparam int TIME_BITS     = 32;
   localparam int WAY_OUT_BITS  = 3;
   localparam int CSR_IDX_BITS  = 1;
   localparam int CSR_DATA_BITS = 16;
   localparam int MODE_BITS     = 2;
   localparam int LFSR_BITS     = 16;

   localparam logic [LFSR_BITS-1:0] LFSR_TAPS = 16'hB400;

   localparam logic OP_LOOKUP = 1'b0;
   localparam logic OP_FILL   = 1'b1;

   localparam logic [CSR_IDX_BITS-1:0] CSR_MODE = 1'b0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_SEED = 1'b1;

   typedef enum logic [MODE_BITS-1:0] {
      REPL_OLDEST = 2'd0,
      REPL_FIFO   = 2'd1,
      REPL_RANDOM = 2'd2,
      REPL_TREE   = 2'd3
   } repl_mode_type;

   typedef struct packed {
      logic                 op;
      logic [ADDR_BITS-1:0] address;
      logic [TIME_BITS-1:0] time_stamp;
   } req_type;

   typedef struct packed {
      logic                    hit;
      logic                    evicted;
      logic [WAY_OUT_BITS-1:0] way;
   } rsp_type;

   // scan outcome handed to the victim logic
   typedef struct packed {
      logic          hit;
      logic          fill;
      repl_mode_type mode;
   } sel_ctrl_type;

   // galois step, never lands on zero
   function automatic logic [LFSR_BITS-1:0] lfsr_step(input logic [LFSR_BITS-1:0] s);
      logic [LFSR_BITS-1:0] t;
      t = s[0] ? ((s >> 1) ^ LFSR_TAPS) : (s >> 1);
      if (t == '0) begin
         t = LFSR_BITS'(1);
      end
      return t;
   endfunction

endpackage

// ===== rtl/sacts_ram.sv =====
// sacts_ram: generic single write port, single read port ram, registered read
// depends on nothing
`timescale 1ns / 1ps

module sacts_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                                   clock,
   input  logic                                   we,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  logic [WIDTH-1:0]                       wdata,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic [WIDTH-1:0]                       rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata <= mem_ff[raddr];
   end

endmodule

// ===== rtl/sacts_victim.sv =====
// sacts_victim: way selection after the tag scan and the per-set metadata update
// depends on sacts_pkg
`timescale 1ns / 1ps

module sacts_victim #(
   parameter int WAYS = 8
) (
   input  sacts_pkg::sel_ctrl_type                                 ctrl,
   input  logic [WAYS-1:0]                                         valid_in,
   input  logic [($clog2(WAYS) == 0 ? 1 : (2**$clog2(WAYS))-1)-1:0] tree_in,
   input  logic [(WAYS > 1 ? $clog2(WAYS) : 1)-1:0]                fifo_in,
   input  logic [(WAYS > 1 ? $clog2(WAYS) : 1)-1:0]                old_way,
   input  logic [(WAYS > 1 ? $clog2(WAYS) : 1)-1:0]                hit_way,
   input  logic [(WAYS > 1 ? $clog2(WAYS) : 1)-1:0]                rnd_way,
   output logic [(WAYS > 1 ? $clog2(WAYS) : 1)-1:0]                sel_way,
   output logic                                                    evicted,
   output logic [WAYS-1:0]                                         valid_out,
   output logic [($clog2(WAYS) == 0 ? 1 : (2**$clog2(WAYS))-1)-1:0] tree_out,
   output logic [(WAYS > 1 ? $clog2(WAYS) : 1)-1:0]                fifo_out,
   output logic                                                    rnd_used
);

   localparam int K         = $clog2(WAYS);
   localparam int WAY_W     = (WAYS > 1) ? K : 1;
   localparam int TREE_BITS = (K == 0) ? 1 : (2**K) - 1;
   localparam int NODE_W    = (TREE_BITS > 1) ? $clog2(TREE_BITS) : 1;

   logic             any_free;
   logic [WAY_W-1:0] free_way;
   logic [WAY_W-1:0] walk_way;
   logic [WAY_W-1:0] miss_way;
   logic [WAY_W-1:0] touch_way;
   logic             fill_miss;
   logic             do_touch;

   // first invalid way
   always_comb begin
      any_free = 1'b0;
      free_way = '0;
      for (int w = WAYS - 1; w >= 0; w--) begin
         if (!valid_in[w]) begin
            any_free = 1'b1;
            free_way = WAY_W'(w);
         end
      end
   end

   // tree walk toward the pseudo-lru leaf
   always_comb begin
      int node;
      int wv;
      node = 0;
      wv   = 0;
      for (int lv = 0; lv < K; lv++) begin
         wv   = (wv << 1) | int'(tree_in[NODE_W'(node)]);
         node = 2 * node + 1 + int'(tree_in[NODE_W'(node)]);
      end
      if (wv >= WAYS) begin
         wv = wv - WAYS;
      end
      walk_way = WAY_W'(wv);
   end

   assign fill_miss = ctrl.fill && !ctrl.hit;

   always_comb begin
      unique case (ctrl.mode)
         sacts_pkg::REPL_OLDEST: miss_way = old_way;
         sacts_pkg::REPL_FIFO:   miss_way = fifo_in;
         sacts_pkg::REPL_RANDOM: miss_way = rnd_way;
         sacts_pkg::REPL_TREE:   miss_way = walk_way;
         default:                miss_way = old_way;
      endcase
      if (any_free) begin
         miss_way = free_way;
      end
   end

   assign sel_way   = ctrl.hit ? hit_way : (fill_miss ? miss_way : '0);
   assign evicted   = fill_miss && valid_in[sel_way];
   assign rnd_used  = fill_miss && !any_free && (ctrl.mode == sacts_pkg::REPL_RANDOM);
   assign touch_way = sel_way;
   assign do_touch  = (ctrl.mode == sacts_pkg::REPL_TREE) &&
                      ((ctrl.hit && !ctrl.fill) || fill_miss);

   always_comb begin
      valid_out = valid_in;
      if (fill_miss) begin
         valid_out[sel_way] = 1'b1;
      end
   end

   always_comb begin
      fifo_out = fifo_in;
      if (fill_miss && !any_free && (ctrl.mode == sacts_pkg::REPL_FIFO)) begin
         fifo_out = (int'(fifo_in) == WAYS - 1) ? '0 : WAY_W'(int'(fifo_in) + 1);
      end
   end

   // point every node on the touched path away from it
   always_comb begin
      int node;
      int b;
      node     = 0;
      b        = 0;
      tree_out = tree_in;
      if (do_touch) begin
         for (int lv = 0; lv < K; lv++) begin
            b = (int'(touch_way) >> (K - 1 - lv)) & 1;
            tree_out[NODE_W'(node)] = (b == 0);
            node = 2 * node + 1 + b;
         end
      end
   end

endmodule

// ===== rtl/set_assoc_cache_tag_store_top.sv =====
// set_assoc_cache_tag_store_top: sequencer, way-serial tag compare and the rams
// depends on sacts_pkg, sacts_ram, sacts_victim
`timescale 1ns / 1ps

// Tag store of a set-associative cache with selectable replacement.
// req channel: one transfer carries op (lookup or fill), byte address and time
// stamp. rsp channel: one transfer per request with hit, evicted and way.
// csr port: index 0 writes the replacement mode, index 1 writes the random
// seed and loads the lfsr (zero loads as one). Writes are taken at any time.
// A request passes through these steps: the set is read, the ways go one per
// cycle through the shared tag and time comparator, then the way is picked and
// written back. req_stall is high from the accepting edge until the block is
// idle again, so a new request is not taken before the last one is written back.
// The result is registered in the decide step, once the output register is free.
// The result sits in an output register; a stalled result holds there while
// the next request is scanned, and the write-back waits until it is taken.
// After reset the block clears the per-set valid, tree and fifo rams, one
// set a cycle; req_stall stays high until every set is cleared.

module set_assoc_cache_tag_store_top #(
   parameter int SETS       = 64,
   parameter int WAYS       = 8,
   parameter int LINE_BYTES = 64
) (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     req_valid,
   output logic                                     req_stall,
   input  sacts_pkg::req_type                       req_data,
   output logic                                     rsp_valid,
   input  logic                                     rsp_stall,
   output sacts_pkg::rsp_type                       rsp_data,
   input  logic                                     csr_we,
   input  logic [sacts_pkg::CSR_IDX_BITS-1:0]       csr_index,
   input  logic [sacts_pkg::CSR_DATA_BITS-1:0]      csr_wdata
);

   localparam int OFF_BITS  = $clog2(LINE_BYTES);
   localparam int IDX_BITS  = $clog2(SETS);
   localparam int SET_W     = (SETS > 1) ? IDX_BITS : 1;
   localparam int K         = $clog2(WAYS);
   localparam int WAY_W     = (WAYS > 1) ? K : 1;
   localparam int LINES     = SETS * WAYS;
   localparam int LINE_W    = (LINES > 1) ? $clog2(LINES) : 1;
   localparam int TREE_BITS = (K == 0) ? 1 : (2**K) - 1;
   localparam int TAG_BITS  = sacts_pkg::ADDR_BITS - OFF_BITS - IDX_BITS;
   localparam int TIME_BITS = sacts_pkg::TIME_BITS;
   localparam int LB        = sacts_pkg::LFSR_BITS;
   localparam logic [SET_W-1:0] IDX_MASK = SET_W'((64'd1 << IDX_BITS) - 64'd1);
   // reciprocal for the lfsr remainder: exact for any 16-bit dividend
   localparam longint unsigned RECIP = ((64'd1 << 32) + WAYS - 1) / WAYS;

   typedef enum logic [3:0] {
      S_CLEAR  = 4'b0001,
      S_IDLE   = 4'b0010,
      S_SCAN   = 4'b0100,
      S_DECIDE = 4'b1000
   } state_type;

   state_type                    state_ff, state_in;
   logic [SET_W-1:0]             clr_ff, clr_in;
   logic [WAY_W-1:0]             cnt_ff, cnt_in;
   sacts_pkg::req_type           req_ff;
   logic [SET_W-1:0]             set_ff;
   logic [TAG_BITS-1:0]          tag_ff;
   logic [WAYS-1:0]              valid_ff;
   logic [TREE_BITS-1:0]         tree_ff;
   logic [WAY_W-1:0]             fifo_ff;
   logic                         hit_ff, hit_in;
   logic [WAY_W-1:0]             hit_way_ff, hit_way_in;
   logic [TIME_BITS-1:0]         old_time_ff, old_time_in;
   logic [WAY_W-1:0]             old_way_ff, old_way_in;
   logic [LB-1:0]                q_ff;
   logic [LB-1:0]                lfsr_ff;
   sacts_pkg::repl_mode_type     mode_ff;
   logic                         rsp_valid_ff;
   sacts_pkg::rsp_type           rsp_ff;

   logic                         req_take;
   logic                         fire;
   logic [SET_W-1:0]             req_set;
   logic [TAG_BITS-1:0]          req_tag;
   logic [sacts_pkg::ADDR_BITS-1:0] addr_sh;
   logic [SET_W-1:0]             idx_raw;
   logic [SET_W-1:0]             meta_raddr;
   logic [LINE_W-1:0]            line_raddr;
   logic [WAY_W-1:0]             rd_way;
   logic [WAYS-1:0]              valid_rd;
   logic [TREE_BITS-1:0]         tree_rd;
   logic [WAY_W-1:0]             fifo_rd;
   logic [TAG_BITS-1:0]          tag_rd;
   logic [TIME_BITS-1:0]         time_rd;
   logic [WAYS-1:0]              valid_now;
   logic                         way_match;
   logic                         way_older;
   logic                         last_way;
   logic [LB-1:0]                lfsr_nx;
   logic [48:0]                  recip_prod;
   logic [WAY_W-1:0]             rnd_way;
   sacts_pkg::sel_ctrl_type      ctrl;
   logic [WAY_W-1:0]             sel_way;
   logic                         sel_evicted;
   logic [WAYS-1:0]              valid_out;
   logic [TREE_BITS-1:0]         tree_out;
   logic [WAY_W-1:0]             fifo_out;
   logic                         rnd_used;
   logic                         meta_we;
   logic [SET_W-1:0]             meta_waddr;
   logic [WAYS-1:0]              valid_wd;
   logic [TREE_BITS-1:0]         tree_wd;
   logic [WAY_W-1:0]             fifo_wd;
   logic                         tag_we;
   logic                         time_we;
   logic [LINE_W-1:0]            line_waddr;

   function automatic logic [LINE_W-1:0] line_of(input logic [SET_W-1:0] s,
                                                input logic [WAY_W-1:0] w);
      return LINE_W'(32'(s) * WAYS + 32'(w));
   endfunction

   // address split; index bits folded into the set range
   always_comb begin
      addr_sh = req_data.address >> OFF_BITS;
      idx_raw = addr_sh[SET_W-1:0] & IDX_MASK;
      req_set = ({1'b0, idx_raw} >= (SET_W + 1)'(SETS)) ? SET_W'(idx_raw - SET_W'(SETS))
                                                          : idx_raw;
      req_tag = TAG_BITS'(req_data.address >> (OFF_BITS + IDX_BITS));
   end

   assign req_take  = req_valid && !req_stall;
   assign req_stall = (state_ff != S_IDLE);
   assign fire      = (state_ff == S_DECIDE) && (!rsp_valid_ff || !rsp_stall);
   assign last_way  = (int'(cnt_ff) == WAYS - 1);

   // read side: set metadata on accept, one way per cycle afterwards
   always_comb begin
      if (state_ff == S_IDLE) begin
         rd_way     = '0;
         meta_raddr = req_set;
         line_raddr = line_of(req_set, '0);
      end else begin
         rd_way     = last_way ? cnt_ff : WAY_W'(int'(cnt_ff) + 1);
         meta_raddr = set_ff;
         line_raddr = line_of(set_ff, rd_way);
      end
   end

   // shared comparator: tag match and older time for the way now on the ram outputs
   assign valid_now = (cnt_ff == '0) ? valid_rd : valid_ff;
   assign way_match = valid_now[cnt_ff] && (tag_rd == tag_ff);
   assign way_older = (cnt_ff == '0) || (time_rd < old_time_ff);

   always_comb begin
      state_in    = state_ff;
      clr_in      = clr_ff;
      cnt_in      = cnt_ff;
      hit_in      = hit_ff;
      hit_way_in  = hit_way_ff;
      old_time_in = old_time_ff;
      old_way_in  = old_way_ff;
      unique case (state_ff)
         S_CLEAR: begin
            clr_in = SET_W'(int'(clr_ff) + 1);
            if (int'(clr_ff) == SETS - 1) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            cnt_in = '0;
            hit_in = 1'b0;
            if (req_take) begin
               state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            if (way_match && !hit_ff) begin
               hit_in     = 1'b1;
               hit_way_in = cnt_ff;
            end
            if (way_older) begin
               old_time_in = time_rd;
               old_way_in  = cnt_ff;
            end
            if (last_way) begin
               state_in = S_DECIDE;
            end else begin
               cnt_in = WAY_W'(int'(cnt_ff) + 1);
            end
         end
         S_DECIDE: begin
            if (fire) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // random victim: next lfsr value modulo the way count
   assign lfsr_nx    = sacts_pkg::lfsr_step(lfsr_ff);
   assign recip_prod = 49'(lfsr_nx) * 49'(RECIP);
   assign rnd_way    = WAY_W'(lfsr_nx - LB'(32'(q_ff) * WAYS));

   assign ctrl = '{hit: hit_ff, fill: (req_ff.op == sacts_pkg::OP_FILL), mode: mode_ff};

   sacts_victim #(
      .WAYS (WAYS)
   ) u_victim (
      .ctrl      (ctrl),
      .valid_in  (valid_ff),
      .tree_in   (tree_ff),
      .fifo_in   (fifo_ff),
      .old_way   (old_way_ff),
      .hit_way   (hit_way_ff),
      .rnd_way   (rnd_way),
      .sel_way   (sel_way),
      .evicted   (sel_evicted),
      .valid_out (valid_out),
      .tree_out  (tree_out),
      .fifo_out  (fifo_out),
      .rnd_used  (rnd_used)
   );

   // write side: clearing pass or write-back of the decided access
   assign meta_we    = (state_ff == S_CLEAR) || fire;
   assign meta_waddr = (state_ff == S_CLEAR) ? clr_ff : set_ff;
   assign valid_wd   = (state_ff == S_CLEAR) ? '0 : valid_out;
   assign tree_wd    = (state_ff == S_CLEAR) ? '0 : tree_out;
   assign fifo_wd    = (state_ff == S_CLEAR) ? '0 : fifo_out;
   assign tag_we     = fire && ctrl.fill && !hit_ff;
   assign time_we    = fire && (hit_ff || ctrl.fill);
   assign line_waddr = line_of(set_ff, sel_way);

   sacts_ram #(.WIDTH(WAYS), .DEPTH(SETS)) u_valid_ram (
      .clock (clock), .we (meta_we), .waddr (meta_waddr), .wdata (valid_wd),
      .raddr (meta_raddr), .rdata (valid_rd)
   );

   sacts_ram #(.WIDTH(TREE_BITS), .DEPTH(SETS)) u_tree_ram (
      .clock (clock), .we (meta_we), .waddr (meta_waddr), .wdata (tree_wd),
      .raddr (meta_raddr), .rdata (tree_rd)
   );

   sacts_ram #(.WIDTH(WAY_W), .DEPTH(SETS)) u_fifo_ram (
      .clock (clock), .we (meta_we), .waddr (meta_waddr), .wdata (fifo_wd),
      .raddr (meta_raddr), .rdata (fifo_rd)
   );

   sacts_ram #(.WIDTH(TAG_BITS), .DEPTH(LINES)) u_tag_ram (
      .clock (clock), .we (tag_we), .waddr (line_waddr), .wdata (tag_ff),
      .raddr (line_raddr), .rdata (tag_rd)
   );

   sacts_ram #(.WIDTH(TIME_BITS), .DEPTH(LINES)) u_time_ram (
      .clock (clock), .we (time_we), .waddr (line_waddr), .wdata (req_ff.time_stamp),
      .raddr (line_raddr), .rdata (time_rd)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         cnt_ff       <= '0;
         hit_ff       <= 1'b0;
         mode_ff      <= sacts_pkg::REPL_OLDEST;
         lfsr_ff      <= LB'(1);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
         cnt_ff   <= cnt_in;
         hit_ff   <= hit_in;
         if (fire) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         if (csr_we && (csr_index == sacts_pkg::CSR_MODE)) begin
            mode_ff <= sacts_pkg::repl_mode_type'(csr_wdata[sacts_pkg::MODE_BITS-1:0]);
         end
         if (csr_we && (csr_index == sacts_pkg::CSR_SEED)) begin
            lfsr_ff <= (csr_wdata == '0) ? LB'(1) : csr_wdata;
         end else if (fire && rnd_used) begin
            lfsr_ff <= lfsr_nx;
         end
      end
   end

   always_ff @(posedge clock) begin
      hit_way_ff  <= hit_way_in;
      old_time_ff <= old_time_in;
      old_way_ff  <= old_way_in;
      if (req_take) begin
         req_ff <= req_data;
         set_ff <= req_set;
         tag_ff <= req_tag;
      end
      if ((state_ff == S_SCAN) && (cnt_ff == '0)) begin
         valid_ff <= valid_rd;
         tree_ff  <= tree_rd;
         fifo_ff  <= fifo_rd;
         q_ff     <= recip_prod[32 +: LB];
      end
      if (fire) begin
         rsp_ff.hit     <= hit_ff;
         rsp_ff.evicted <= sel_evicted;
         rsp_ff.way     <= sacts_pkg::WAY_OUT_BITS'(sel_way);
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

`ifndef SYNTH
   a_state_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot(state_ff))
      else $error("state register lost its one-hot code");

   a_accept_scans: assert property (@(posedge clock) disable iff (reset)
      req_take |=> (state_ff == S_SCAN) && (cnt_ff == '0))
      else $error("accepted request did not start the way scan");

   a_rsp_from_decide: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == S_DECIDE))
      else $error("result raised outside the decide step");

   a_hit_not_evict: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_ff.hit && rsp_ff.evicted))
      else $error("result reports both hit and eviction");
`endif

endmodule

// ===== test/tb_top.sv =====
// tb_top: self-checking bench for the cache tag store, with a built-in tag/lru predictor
// depends on sacts_pkg and set_assoc_cache_tag_store_top
`timescale 1ns / 1ps

module tb_top;

   localparam int NSETS = 64;
   localparam int NWAYS = 8;
   localparam int RING  = 64;

   // predicts every response and checks the responses in order
   class tag_scoreboard;
      bit                       line_ok[NSETS][NWAYS];
      bit [27:0]                line_tag[NSETS][NWAYS];
      bit [31:0]                last_use[NSETS][NWAYS];
      bit [6:0]                 tree_bits[NSETS];
      bit [2:0]                 fifo_ptr[NSETS];
      bit [15:0]                lfsr;
      sacts_pkg::repl_mode_type mode;
      sacts_pkg::rsp_type       exp_ring[RING];
      int                       ring_rd;
      int                       ring_wr;
      int                       ring_cnt;
      int                       mismatches;
      int                       strays;
      int                       checked;
      int                       hits;
      int                       evictions;

      function new();
         mode = sacts_pkg::REPL_OLDEST;
         lfsr = 16'd1;
         ring_rd = 0;
         ring_wr = 0;
         ring_cnt = 0;
      endfunction

      function int outstanding();
         return ring_cnt;
      endfunction

      function void write_reg(logic [sacts_pkg::CSR_IDX_BITS-1:0] idx, logic [15:0] data);
         if (idx == sacts_pkg::CSR_MODE) begin
            mode = sacts_pkg::repl_mode_type'(data[1:0]);
         end else if (idx == sacts_pkg::CSR_SEED) begin
            lfsr = (data == 16'd0) ? 16'd1 : data;
         end
      endfunction

      function void touch_tree(int set, bit [2:0] way);
         int node;
         bit b;
         node = 0;
         for (int lvl = 0; lvl < 3; lvl++) begin
            b = way[2-lvl];
            tree_bits[set][node] = !b;
            node = 2 * node + 1 + b;
         end
      endfunction

      function bit [2:0] choose_victim(int set);
         bit [2:0] v;
         bit [31:0] oldest;
         int node;
         bit b;
         for (int w = 0; w < NWAYS; w++) begin
            if (!line_ok[set][w]) return w[2:0];
         end
         v = '0;
         case (mode)
            sacts_pkg::REPL_OLDEST: begin
               oldest = last_use[set][0];
               for (int w = 1; w < NWAYS; w++) begin
                  if (last_use[set][w] < oldest) begin
                     oldest = last_use[set][w];
                     v = w[2:0];
                  end
               end
            end
            sacts_pkg::REPL_FIFO: begin
               v = fifo_ptr[set];
               fifo_ptr[set] = v + 3'd1;
            end
            sacts_pkg::REPL_RANDOM: begin
               lfsr = lfsr[0] ? ((lfsr >> 1) ^ 16'hB400) : (lfsr >> 1);
               if (lfsr == 16'd0) lfsr = 16'd1;
               v = lfsr[2:0];
            end
            default: begin
               node = 0;
               for (int lvl = 0; lvl < 3; lvl++) begin
                  b = tree_bits[set][node];
                  v = {v[1:0], b};
                  node = 2 * node + 1 + b;
               end
            end
         endcase
         return v;
      endfunction

      function void note_request(sacts_pkg::req_type r);
         sacts_pkg::rsp_type e;
         int set;
         bit [27:0] tg;
         bit [2:0] v;
         e = '0;
         set = int'(r.address[11:6]);
         tg = r.address[39:12];
         for (int w = 0; w < NWAYS; w++) begin
            if (!e.hit && line_ok[set][w] && line_tag[set][w] == tg) begin
               last_use[set][w] = r.time_stamp;
               if (r.op == sacts_pkg::OP_LOOKUP && mode == sacts_pkg::REPL_TREE)
                  touch_tree(set, w[2:0]);
               e.hit = 1'b1;
               e.way = w[2:0];
            end
         end
         if (!e.hit && r.op == sacts_pkg::OP_FILL) begin
            v = choose_victim(set);
            e.evicted = line_ok[set][v];
            line_ok[set][v] = 1'b1;
            line_tag[set][v] = tg;
            last_use[set][v] = r.time_stamp;
            if (mode == sacts_pkg::REPL_TREE) touch_tree(set, v);
            e.way = v;
         end
         hits += int'(e.hit);
         evictions += int'(e.evicted);
         exp_ring[ring_wr] = e;
         ring_wr = (ring_wr + 1) % RING;
         ring_cnt++;
      endfunction

      function void check_response(sacts_pkg::rsp_type got);
         sacts_pkg::rsp_type e;
         if (ring_cnt == 0) begin
            strays++;
            $display("unexpected response hit=%0b evicted=%0b way=%0d",
                     got.hit, got.evicted, got.way);
            return;
         end
         e = exp_ring[ring_rd];
         ring_rd = (ring_rd + 1) % RING;
         ring_cnt--;
         checked++;
         if (got.hit !== e.hit || got.evicted !== e.evicted || got.way !== e.way) begin
            mismatches++;
            if (mismatches <= 10)
               $display("mismatch #%0d: expected hit=%0b evicted=%0b way=%0d, %s",
                        mismatches, e.hit, e.evicted, e.way,
                        $sformatf("got hit=%0b evicted=%0b way=%0d",
                                  got.hit, got.evicted, got.way));
         end
      endfunction
   endclass

   logic                                  clock;
   logic                                  reset;
   logic                                  req_valid;
   logic                                  req_stall;
   sacts_pkg::req_type                    req_data;
   logic                                  rsp_valid;
   logic                                  rsp_stall;
   sacts_pkg::rsp_type                    rsp_data;
   logic                                  csr_we;
   logic [sacts_pkg::CSR_IDX_BITS-1:0]    csr_index;
   logic [sacts_pkg::CSR_DATA_BITS-1:0]   csr_wdata;

   tag_scoreboard sb;
   int send_idle_pct;
   int rcv_stall_pct;
   int hold_cycles;
   bit [27:0] tag_pool[12];
   bit [5:0]  set_pool[4];
   bit [31:0] clock_now;

   set_assoc_cache_tag_store_top uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #2000000;
      $display("timeout");
      $display("tb_top: errors");
      $finish;
   end

   // receiver: random stall, plus a long hold-off when requested
   initial begin
      bit take;
      sacts_pkg::rsp_type d;
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         take = rsp_valid && !rsp_stall;
         d = rsp_data;
         @(posedge clock);
         if (take && !reset) sb.check_response(d);
         if (hold_cycles > 0) begin
            hold_cycles--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= ($urandom_range(0, 99) < rcv_stall_pct);
         end
      end
   end

   task automatic send_req(sacts_pkg::req_type r);
      bit s;
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      do begin
         @(negedge clock);
         s = req_stall;
         @(posedge clock);
      end while (s);
      sb.note_request(r);
   endtask

   task automatic write_csr(logic [sacts_pkg::CSR_IDX_BITS-1:0] idx, logic [15:0] data);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      csr_we    <= 1'b0;
      sb.write_reg(idx, data);
   endtask

   // let every response come back, then the block's own busy window
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.outstanding() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   function automatic sacts_pkg::req_type make_req(bit op, bit [27:0] tg, bit [5:0] set,
                                                   bit [31:0] ts);
      sacts_pkg::req_type r;
      r.op = op;
      r.address = {tg, set, 6'($urandom_range(0, 63))};
      r.time_stamp = ts;
      return r;
   endfunction

   function automatic sacts_pkg::req_type random_req();
      sacts_pkg::req_type r;
      if ($urandom_range(0, 99) < 10) begin
         clock_now = $urandom();
      end else begin
         clock_now += $urandom_range(0, 3);
      end
      if ($urandom_range(0, 99) < 15) begin
         r.op = 1'($urandom_range(0, 1));
         r.address = {8'($urandom()), 32'($urandom())};
         r.time_stamp = clock_now;
      end else begin
         r = make_req($urandom_range(0, 99) < 55, tag_pool[$urandom_range(0, 11)],
                      set_pool[$urandom_range(0, 3)], clock_now);
      end
      return r;
   endfunction

   initial begin
      sacts_pkg::repl_mode_type phase_mode[8];
      logic [15:0]              phase_seed[8];
      sacts_pkg::req_type       r;
      sb = new();
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      csr_we = 1'b0;
      csr_index = sacts_pkg::CSR_MODE;
      csr_wdata = '0;
      send_idle_pct = 25;
      rcv_stall_pct = 65;
      hold_cycles = 0;
      clock_now = 32'd1000;
      tag_pool[0] = '0;
      tag_pool[1] = '1;
      for (int i = 2; i < 12; i++) tag_pool[i] = $urandom();
      set_pool = '{6'd0, 6'd63, 6'd5, 6'($urandom_range(0, 63))};
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: empty miss, fill a set with tied times, evictions, present-line fill
      send_req(make_req(sacts_pkg::OP_LOOKUP, 28'd1, 6'd0, 32'd0));
      for (int w = 0; w < NWAYS; w++)
         send_req(make_req(sacts_pkg::OP_FILL, 28'(w + 1), 6'd0, 32'd100));
      send_req(make_req(sacts_pkg::OP_FILL, 28'd9, 6'd0, 32'd200));   // tie goes to lowest way
      send_req(make_req(sacts_pkg::OP_LOOKUP, 28'd3, 6'd0, 32'hFFFF_FFFF));
      send_req(make_req(sacts_pkg::OP_LOOKUP, 28'd77, 6'd0, 32'd5));
      send_req(make_req(sacts_pkg::OP_FILL, 28'd2, 6'd0, 32'd0));     // already present
      send_req(make_req(sacts_pkg::OP_FILL, 28'd10, 6'd0, 32'd300));  // oldest is way 1 at 0
      r.op = sacts_pkg::OP_FILL;  r.address = '1; r.time_stamp = '1;
      send_req(r);
      r.op = sacts_pkg::OP_LOOKUP;
      send_req(r);
      r.address = '0;  r.time_stamp = '0;
      send_req(r);
      r.op = sacts_pkg::OP_FILL;
      send_req(r);
      drain();

      phase_mode = '{sacts_pkg::REPL_OLDEST, sacts_pkg::REPL_FIFO, sacts_pkg::REPL_RANDOM,
                     sacts_pkg::REPL_TREE, sacts_pkg::REPL_RANDOM, sacts_pkg::REPL_OLDEST,
                     sacts_pkg::REPL_TREE, sacts_pkg::REPL_FIFO};
      phase_seed = '{16'd1, 16'h1234, 16'h0000, 16'h00A5,
                     16'hFFFF, 16'h8001, 16'h0001, 16'h7FFF};
      for (int p = 0; p < 8; p++) begin
         if (p < 3) begin
            send_idle_pct = 25;  rcv_stall_pct = 65;
         end else if (p < 6) begin
            send_idle_pct = 65;  rcv_stall_pct = 25;
         end else begin
            send_idle_pct = 0;   rcv_stall_pct = 0;
         end
         // upper data bits on a mode write must be ignored
         write_csr(sacts_pkg::CSR_MODE, (p == 5) ? {14'h3FFF, 2'(phase_mode[p])}
                                                 : 16'(phase_mode[p]));
         write_csr(sacts_pkg::CSR_SEED, phase_seed[p]);
         if (p == 1) hold_cycles = 400;
         for (int i = 0; i < 85; i++) send_req(random_req());
         drain();
      end

      $display("covered %0d responses over all four replacement modes", sb.checked);
      $display("%0d hits, %0d evictions, mismatches %0d, unexpected %0d",
               sb.hits, sb.evictions, sb.mismatches, sb.strays);
      if (sb.mismatches == 0 && sb.strays == 0 && sb.outstanding() == 0) begin
         $display("tb_top: clean");
      end else begin
         $display("tb_top: errors");
      end
      $finish;
   end

endmodule
